// ----- hw/rtl/atbf_pkg.sv -----
// Shared types, constants and the binary header prefix for the response framer.
`timescale 1ns / 1ps
`default_nettype none
package atbf_pkg;

   localparam logic [12:0] FRAME_LIMIT     = 13'd4096;
   localparam logic [12:0] MAX_FRAME_RESET = 13'd1024;
   localparam logic [12:0] PREFIX_BYTES    = 13'd10;
   localparam logic [12:0] LEN_HI_POS      = 13'd11;
   localparam logic [12:0] HEADER_BYTES    = 13'd12;
   localparam logic [7:0]  CHAR_CR         = 8'h0D;
   localparam logic [7:0]  CHAR_LF         = 8'h0A;

   typedef enum logic [1:0] {
      KIND_TEXT     = 2'd0,
      KIND_BINARY   = 2'd1,
      KIND_OVERFLOW = 2'd2
   } frame_kind_type;

   typedef struct packed {
      logic [7:0]     out_byte;
      logic           frame_end;
      frame_kind_type frame_kind;
      logic [12:0]    frame_length;
   } rsp_payload_type;

   // "$$BinRecv:" by position 0..9
   function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
      logic [7:0] b;
      unique case (idx)
         4'd0:    b = 8'h24;
         4'd1:    b = 8'h24;
         4'd2:    b = 8'h42;
         4'd3:    b = 8'h69;
         4'd4:    b = 8'h6E;
         4'd5:    b = 8'h52;
         4'd6:    b = 8'h65;
         4'd7:    b = 8'h63;
         4'd8:    b = 8'h76;
         4'd9:    b = 8'h3A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/atbf_if.sv -----
// Request and response channel interfaces of the response framer.
`timescale 1ns / 1ps
`default_nettype none
interface atbf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atbf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        frame_end;
   logic [1:0]  frame_kind;
   logic [12:0] frame_length;

   modport source (output valid, output out_byte, output frame_end, output frame_kind,
                   output frame_length, input ready);
   modport sink   (input valid, input out_byte, input frame_end, input frame_kind,
                   input frame_length, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/atbf_framer_core.sv -----
// Frame state, capacity register and per-byte framing decision.
`timescale 1ns / 1ps
`default_nettype none
module atbf_framer_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [12:0]               csr_wdata,
   input  wire logic                      accept,
   input  wire logic [7:0]                rx_byte,
   output      atbf_pkg::rsp_payload_type result
);

   logic [12:0] max_frame_ff;
   logic [12:0] byte_count_ff, byte_count_in;
   logic        prefix_ok_ff, prefix_ok_in;
   logic        in_binary_ff, in_binary_in;
   logic [11:0] payload_length_ff, payload_length_in;

   logic [12:0] limit;
   logic [12:0] count_inc;
   logic [12:0] bin_end;

   assign limit = (max_frame_ff > atbf_pkg::FRAME_LIMIT) ? atbf_pkg::FRAME_LIMIT : max_frame_ff;
   assign count_inc = byte_count_ff + 13'd1;
   assign bin_end   = atbf_pkg::HEADER_BYTES + {1'b0, payload_length_ff};

   always_comb begin
      byte_count_in       = count_inc;
      prefix_ok_in        = prefix_ok_ff;
      in_binary_in        = in_binary_ff;
      payload_length_in   = payload_length_ff;
      result.out_byte     = rx_byte;
      result.frame_end    = 1'b0;
      result.frame_kind   = atbf_pkg::KIND_TEXT;
      result.frame_length = 13'd0;

      if (count_inc <= atbf_pkg::PREFIX_BYTES) begin
         if (rx_byte != atbf_pkg::prefix_byte(count_inc[3:0] - 4'd1)) begin
            prefix_ok_in = 1'b0;
         end
      end else if (count_inc == atbf_pkg::LEN_HI_POS) begin
         payload_length_in = {rx_byte[3:0], 8'h00};
      end

      // twelfth byte: never a terminator or binary end
      if (count_inc == atbf_pkg::HEADER_BYTES) begin
         payload_length_in = {payload_length_ff[11:8], rx_byte};
         in_binary_in      = prefix_ok_ff;
      end else if (in_binary_ff) begin
         if (count_inc >= bin_end) begin
            result.frame_end    = 1'b1;
            result.frame_kind   = atbf_pkg::KIND_BINARY;
            result.frame_length = count_inc;
         end
      end else if (rx_byte == atbf_pkg::CHAR_CR || rx_byte == atbf_pkg::CHAR_LF) begin
         result.out_byte     = 8'h00;
         result.frame_end    = 1'b1;
         result.frame_kind   = atbf_pkg::KIND_TEXT;
         result.frame_length = byte_count_ff;
      end

      if (!result.frame_end && count_inc >= limit) begin
         result.frame_end    = 1'b1;
         result.frame_kind   = atbf_pkg::KIND_OVERFLOW;
         result.frame_length = 13'd0;
      end

      if (result.frame_end) begin
         byte_count_in     = 13'd0;
         prefix_ok_in      = 1'b1;
         in_binary_in      = 1'b0;
         payload_length_in = 12'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff      <= atbf_pkg::MAX_FRAME_RESET;
         byte_count_ff     <= 13'd0;
         prefix_ok_ff      <= 1'b1;
         in_binary_ff      <= 1'b0;
         payload_length_ff <= 12'd0;
      end else begin
         if (csr_we) begin
            max_frame_ff <= csr_wdata;
         end
         if (accept) begin
            byte_count_ff     <= byte_count_in;
            prefix_ok_ff      <= prefix_ok_in;
            in_binary_ff      <= in_binary_in;
            payload_length_ff <= payload_length_in;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/atbf_out_buffer.sv -----
// Response register with skid stage; input is held off while the skid stage is full.
`timescale 1ns / 1ps
`default_nettype none
module atbf_out_buffer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output      logic                      in_ready,
   input  wire atbf_pkg::rsp_payload_type in_data,
   output      logic                      out_valid,
   input  wire logic                      out_ready,
   output      atbf_pkg::rsp_payload_type out_data
);

   logic                      main_valid_ff, main_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   atbf_pkg::rsp_payload_type main_data_ff, main_data_in;
   atbf_pkg::rsp_payload_type skid_data_ff, skid_data_in;
   logic                      take;
   logic                      load;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign take      = main_valid_ff && out_ready;
   assign load      = in_valid && in_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (take) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (!main_valid_ff || take) begin
            main_valid_in = 1'b1;
            main_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/at_response_binary_framer_unit.sv -----
// Top level of the modem response framer.
// Takes one received byte per request and returns one response per byte: the byte
// (a text-line CR/LF replaced by 0), an end-of-frame flag, the frame kind (text,
// binary, overflow) and its length. A frame whose bytes 1-10 are "$$BinRecv:" is
// binary, with its payload length in bytes 11-12. A request is accepted every
// cycle while the skid register is empty; its response is registered in the main
// register, or in the skid register while one waits, the framing decision being
// one pass of logic between the frame state and the response register. A two-deep
// response buffer keeps the request side running while a response waits. csr_wdata
// sets the frame limit (reset 1024, clamped to 4096); write it only while idle.
`timescale 1ns / 1ps
`default_nettype none
module at_response_binary_framer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   atbf_req_if.sink         req_if,
   atbf_rsp_if.source       rsp_if,
   input  wire logic        csr_we,
   input  wire logic [12:0] csr_wdata
);

   logic                      req_ready;
   logic                      accept;
   atbf_pkg::rsp_payload_type step_result;
   atbf_pkg::rsp_payload_type rsp_data;

   assign req_if.ready = req_ready;
   assign accept       = req_if.valid && req_ready;

   atbf_framer_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .rx_byte   (req_if.rx_byte),
      .result    (step_result)
   );

   atbf_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_ready),
      .in_data   (step_result),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_data)
   );

   assign rsp_if.out_byte     = rsp_data.out_byte;
   assign rsp_if.frame_end    = rsp_data.frame_end;
   assign rsp_if.frame_kind   = rsp_data.frame_kind;
   assign rsp_if.frame_length = rsp_data.frame_length;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the modem response framer: table-driven and random byte streams.
`timescale 1ns / 1ps
module testbench;
   import atbf_pkg::*;

   localparam logic [79:0] BIN_HEADER = "$$BinRecv:";
   localparam rsp_payload_type NO_END = '{8'h00, 1'b0, KIND_TEXT, 13'd0};

   typedef struct {
      logic [7:0]      rx;
      bit              typed;
      rsp_payload_type want;
   } stim_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        csr_we    = 1'b0;
   logic [12:0] csr_wdata = 13'd0;

   atbf_req_if req_ch ();
   atbf_rsp_if rsp_ch ();

   at_response_binary_framer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // framer image
   logic [12:0] cap_reg;
   logic [12:0] cnt;
   bit          pfx_ok;
   bit          binary_on;
   logic [11:0] pay_len;

   rsp_payload_type due_rsp_q[$];
   int  fail_count = 0;
   int  sent_count = 0;
   int  text_seen = 0, binary_seen = 0, overflow_seen = 0;
   bit  gaps_on = 1'b1;
   int  burst_left = 0;
   bit  hold_go = 1'b0;

   function automatic logic [7:0] header_char(input int pos);
      return BIN_HEADER[79 - 8 * pos -: 8];
   endfunction

   function automatic void clear_frame();
      cnt       = 13'd0;
      pfx_ok    = 1'b1;
      binary_on = 1'b0;
      pay_len   = 12'd0;
   endfunction

   function automatic rsp_payload_type frame_step(input logic [7:0] b);
      rsp_payload_type r;
      int lim;
      r = '{out_byte: b, frame_end: 1'b0, frame_kind: KIND_TEXT, frame_length: 13'd0};
      lim = (cap_reg > FRAME_LIMIT) ? int'(FRAME_LIMIT) : int'(cap_reg);
      cnt = cnt + 13'd1;
      if (cnt <= PREFIX_BYTES) begin
         if (b != header_char(int'(cnt) - 1)) pfx_ok = 1'b0;
      end else if (cnt == LEN_HI_POS) begin
         pay_len = {b[3:0], 8'h00};
      end
      if (cnt == HEADER_BYTES) begin
         pay_len[7:0] = b;
         binary_on = pfx_ok;
      end else if (binary_on) begin
         if (int'(cnt) >= int'(HEADER_BYTES) + int'(pay_len)) begin
            r.frame_end    = 1'b1;
            r.frame_kind   = KIND_BINARY;
            r.frame_length = cnt;
         end
      end else if (b == CHAR_CR || b == CHAR_LF) begin
         r.out_byte     = 8'h00;
         r.frame_end    = 1'b1;
         r.frame_kind   = KIND_TEXT;
         r.frame_length = cnt - 13'd1;
      end
      if (!r.frame_end && int'(cnt) >= lim) begin
         r.frame_end    = 1'b1;
         r.frame_kind   = KIND_OVERFLOW;
         r.frame_length = 13'd0;
      end
      if (r.frame_end) clear_frame();
      return r;
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   task automatic offer(input logic [7:0] b, input bit typed = 1'b0,
                        input rsp_payload_type typed_rsp = NO_END);
      rsp_payload_type pred;
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      pred = frame_step(b);
      due_rsp_q.push_back(typed ? typed_rsp : pred);
      sent_count++;
   endtask

   task automatic send_line(input int len, input bit term_at_12);
      logic [7:0] term;
      term = ($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_LF;
      for (int i = 0; i < len; i++) begin
         if (term_at_12 && i == 11) offer(term);
         else offer(plain_byte());
      end
      offer(term);
   endtask

   task automatic send_binary(input int plen, input bit corrupt);
      int bad;
      bad = corrupt ? int'($urandom_range(0, 9)) : -1;
      for (int i = 0; i < 10; i++) begin
         if (i == bad) offer(header_char(i) ^ 8'($urandom_range(1, 255)));
         else offer(header_char(i));
      end
      offer({4'($urandom_range(0, 15)), 4'(plen >> 8)});
      offer(8'(plen));
      if (corrupt) send_line($urandom_range(0, 20), 1'b0);
      else repeat ((plen == 0) ? 1 : plen) offer(8'($urandom_range(0, 255)));
   endtask

   task automatic random_frame();
      int r, k;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         k = $urandom_range(0, 39);
         if (k == 0) send_binary($urandom_range(256, 600), 1'b0);
         else if (k < 4) send_binary($urandom_range(41, 255), 1'b0);
         else send_binary($urandom_range(0, 40), 1'b0);
      end else if (r < 80) begin
         if ($urandom_range(0, 6) == 0) send_line($urandom_range(12, 24), 1'b1);
         else send_line($urandom_range(0, 40), 1'b0);
      end else if (r < 90) begin
         send_binary(0, 1'b1);
      end else begin
         repeat ($urandom_range(1, 30)) offer(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic write_capacity(input logic [12:0] v);
      req_ch.valid <= 1'b0;
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we  <= 1'b0;
      cap_reg = v;
   endtask

   initial begin : stimulus
      stim_row_type tab[26];
      logic [12:0]  caps[11];
      int           quota_end;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      cap_reg = MAX_FRAME_RESET;
      clear_frame();
      tab = '{
         '{8'h24, 1'b1, '{8'h24, 1'b0, KIND_TEXT, 13'd0}},
         '{8'h24, 1'b0, NO_END}, '{8'h42, 1'b0, NO_END}, '{8'h69, 1'b0, NO_END},
         '{8'h6E, 1'b0, NO_END}, '{8'h52, 1'b0, NO_END}, '{8'h65, 1'b0, NO_END},
         '{8'h63, 1'b0, NO_END}, '{8'h76, 1'b0, NO_END}, '{8'h3A, 1'b0, NO_END},
         '{8'hF0, 1'b1, '{8'hF0, 1'b0, KIND_TEXT, 13'd0}},
         '{8'h00, 1'b1, '{8'h00, 1'b0, KIND_TEXT, 13'd0}},
         // empty binary payload ends on the byte after the header
         '{8'hFF, 1'b1, '{8'hFF, 1'b1, KIND_BINARY, 13'd13}},
         '{8'h24, 1'b0, NO_END}, '{8'h24, 1'b0, NO_END}, '{8'h42, 1'b0, NO_END},
         '{8'h69, 1'b0, NO_END}, '{8'h6E, 1'b0, NO_END}, '{8'h52, 1'b0, NO_END},
         '{8'h65, 1'b0, NO_END}, '{8'h63, 1'b0, NO_END}, '{8'h76, 1'b0, NO_END},
         '{8'h3B, 1'b0, NO_END}, '{8'h7F, 1'b0, NO_END},
         // CR as twelfth byte is not a terminator
         '{8'h0D, 1'b1, '{8'h0D, 1'b0, KIND_TEXT, 13'd0}},
         '{8'h0A, 1'b1, '{8'h00, 1'b1, KIND_TEXT, 13'd12}}
      };
      caps = '{13'd1024, 13'd40, 13'd0, 13'd1, 13'd13, 13'd12, 13'd300,
               13'd8191, 13'd4097, 13'd4096, 13'd2000};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (tab[i]) offer(tab[i].rx, tab[i].typed, tab[i].want);
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         if (p == 0) begin
            gaps_on = 1'b0;
            hold_go = 1'b1;
         end
         // line frame ending exactly on the capacity, binary frame with a payload of capacity minus 13 bytes
         if (caps[p] >= 13'd13 && caps[p] <= 13'd400) begin
            send_line(int'(caps[p]) - 1, 1'b0);
            send_binary(int'(caps[p]) - 13, 1'b0);
         end
         quota_end = sent_count + 70;
         while (sent_count < quota_end) begin
            if (p != 0) gaps_on = ($urandom_range(0, 3) != 0);
            random_frame();
         end
      end
      req_ch.valid <= 1'b0;
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("%0d requests over %0d capacity settings, held-off receiver included",
               sent_count, $size(caps));
      $display("frames closed: %0d text, %0d binary, %0d overflow",
               text_seen, binary_seen, overflow_seen);
      if (fail_count == 0 && due_rsp_q.size() == 0) begin
         $display("at_response_binary_framer_unit regression: pass");
      end else begin
         $display("at_response_binary_framer_unit regression: fail");
      end
      $finish;
   end

   initial begin : rsp_side
      rsp_payload_type want;
      int mode, mode_left, hold_left;
      bit hold_started;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      hold_started = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (due_rsp_q.size() == 0) begin
               $error("response with no request outstanding: out_byte %0h", rsp_ch.out_byte);
               fail_count++;
            end else begin
               want = due_rsp_q.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_ch.out_byte);
                  fail_count++;
               end
               if (rsp_ch.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_ch.frame_end);
                  fail_count++;
               end
               if (rsp_ch.frame_kind !== want.frame_kind) begin
                  $error("frame_kind: expected %0d, got %0d", want.frame_kind,
                         rsp_ch.frame_kind);
                  fail_count++;
               end
               if (rsp_ch.frame_length !== want.frame_length) begin
                  $error("frame_length: expected %0d, got %0d", want.frame_length,
                         rsp_ch.frame_length);
                  fail_count++;
               end
            end
            if (rsp_ch.frame_end === 1'b1) begin
               case (rsp_ch.frame_kind)
                  KIND_TEXT:     text_seen++;
                  KIND_BINARY:   binary_seen++;
                  KIND_OVERFLOW: overflow_seen++;
                  default:       ;
               endcase
            end
         end
         if (hold_go && !hold_started) begin
            hold_started = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #6_000_000;
      $display("at_response_binary_framer_unit regression: fail");
      $finish;
   end

endmodule
